FILE: rtl/che_pkg.sv
// Shared types, codes and helpers for the canonical Huffman encoder.
package che_pkg;

	localparam int SYMBOLS_DEF      = 256;
	localparam int MAX_CODE_LEN_DEF = 31;
	localparam int LEN_W            = 5;
	localparam int SYM_FIELD_W      = 8;
	localparam int RUN_W            = 32;

	localparam logic [1:0] OP_LOAD   = 2'd0;
	localparam logic [1:0] OP_BUILD  = 2'd1;
	localparam logic [1:0] OP_ENCODE = 2'd2;
	localparam logic [1:0] OP_FLUSH  = 2'd3;

	localparam logic [1:0] KIND_DATA  = 2'd0;
	localparam logic [1:0] KIND_BUILT = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	typedef struct packed {
		logic [1:0]             op;
		logic [SYM_FIELD_W-1:0] symbol;
		logic [LEN_W-1:0]       length;
	} che_in_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] out_byte;
		logic       last;
	} che_out_t;

	function automatic logic [RUN_W-1:0] len_mask(input logic [LEN_W-1:0] n);
		len_mask = (RUN_W'(1) << n) - RUN_W'(1);
	endfunction

endpackage

FILE: rtl/canonical_huffman_encoder.sv
// Top level of the canonical Huffman encoder: sequencer, build walk and bit packer.
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid, req_stall  | op, symbol, length
//   rsp     | out       | rsp_valid, rsp_stall  | kind, out_byte, last
//
// A load writes the length table. A build reads the whole length table once per code
// length, from 1 to MAX_CODE_LEN, then reports its result. An encode packs the symbol's
// code into the bit buffer, then emits each full byte. A flush emits the low byte of the
// bit buffer and clears it. Reset clears the length table at once through valid flags.
// Output stalls hold the sequencer; the last result of a word waits in the output register.
module canonical_huffman_encoder
	import che_pkg::*;
#(
	parameter int SYMBOLS      = SYMBOLS_DEF,
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  che_in_t  req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output che_out_t rsp
);

	localparam int SYM_W  = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
	localparam int CODE_W = MAX_CODE_LEN;
	localparam int BUF_W  = MAX_CODE_LEN + 7;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_BUILD = 3'd1;
	localparam logic [2:0] ST_BDONE = 3'd2;
	localparam logic [2:0] ST_ENC   = 3'd3;
	localparam logic [2:0] ST_ERR   = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;
	localparam logic [2:0] ST_FLUSH = 3'd6;

	logic [2:0] state_q;
	logic [SYM_W-1:0] scan_q;
	logic [LEN_W-1:0] blen_q;
	logic [RUN_W-1:0] run_q;
	logic [LEN_W-1:0] prev_q;
	logic [BUF_W-1:0] buf_q;
	logic [2:0] cnt_q;
	logic [2:0] full_q;

	logic pv_s1;
	logic [SYM_W-1:0] sym_s1;
	logic [LEN_W-1:0] blen_s1;
	logic in_range_s1;

	logic req_ok;
	logic sym_in_range;
	logic [LEN_W-1:0] len_sat;
	logic len_we;
	logic [SYM_W-1:0] raddr;
	logic [LEN_W-1:0] lrd;
	logic [CODE_W-1:0] crd;

	logic hit;
	logic [RUN_W-1:0] run_sh;
	logic code_we;
	logic [CODE_W-1:0] code_wdata;

	logic [CODE_W-1:0] masked;
	logic [CODE_W-1:0] rev_full;
	logic [CODE_W-1:0] rev;
	logic [BUF_W-1:0] ins;
	logic [5:0] total;

	logic out_free;
	logic push;
	che_out_t push_word;

	assign req_ok       = req_valid && !req_stall;
	assign req_stall    = (state_q != ST_IDLE);
	assign sym_in_range = ({1'b0, req.symbol} < 9'(SYMBOLS));
	assign len_sat      = (req.length > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
		: req.length;
	assign len_we       = req_ok && (req.op == OP_LOAD) && sym_in_range;
	assign raddr        = (state_q == ST_BUILD) ? scan_q : req.symbol[SYM_W-1:0];

	che_len_mem #(
		.SYMBOLS(SYMBOLS)
	) u_len_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (len_we),
		.waddr (req.symbol[SYM_W-1:0]),
		.wdata (len_sat),
		.raddr (raddr),
		.rdata (lrd)
	);

	assign hit        = pv_s1 && (lrd == blen_s1);
	assign run_sh     = run_q << (blen_s1 - prev_q);
	assign code_we    = hit;
	assign code_wdata = CODE_W'(run_sh & len_mask(blen_s1));

	che_code_mem #(
		.SYMBOLS     (SYMBOLS),
		.MAX_CODE_LEN(MAX_CODE_LEN)
	) u_code_mem (
		.clk  (clk),
		.we   (code_we),
		.waddr(sym_s1),
		.wdata(code_wdata),
		.raddr(raddr),
		.rdata(crd)
	);

	assign masked = crd & CODE_W'(len_mask(lrd));

	always_comb begin
		for (int i = 0; i < CODE_W; i++) begin
			rev_full[i] = masked[CODE_W-1-i];
		end
	end

	assign rev   = rev_full >> (LEN_W'(CODE_W) - lrd);
	assign ins   = BUF_W'(rev) << cnt_q;
	assign total = 6'(lrd) + 6'(cnt_q);

	always_comb begin
		push_word = '0;
		push      = 1'b0;
		case (state_q)
			ST_BDONE: begin
				push_word.kind = KIND_BUILT;
				push_word.last = 1'b1;
				push           = out_free;
			end
			ST_ERR: begin
				push_word.kind = KIND_ERROR;
				push_word.last = 1'b1;
				push           = out_free;
			end
			ST_EMIT: begin
				push_word.kind     = KIND_DATA;
				push_word.out_byte = buf_q[7:0];
				push_word.last     = (full_q == 3'd1);
				push               = out_free;
			end
			ST_FLUSH: begin
				push_word.kind     = KIND_DATA;
				push_word.out_byte = buf_q[7:0];
				push_word.last     = 1'b1;
				push               = out_free;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	che_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_word(push_word),
		.free     (out_free),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always_ff @(posedge clk) begin
		sym_s1      <= scan_q;
		blen_s1     <= blen_q;
		in_range_s1 <= sym_in_range;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			scan_q  <= '0;
			blen_q  <= '0;
			run_q   <= '0;
			prev_q  <= '0;
			buf_q   <= '0;
			cnt_q   <= '0;
			full_q  <= '0;
			pv_s1   <= 1'b0;
		end else begin
			pv_s1 <= (state_q == ST_BUILD);
			if (hit) begin
				run_q  <= run_sh + RUN_W'(1);
				prev_q <= blen_s1;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_ok) begin
						case (req.op)
							OP_BUILD: begin
								state_q <= ST_BUILD;
								scan_q  <= '0;
								blen_q  <= LEN_W'(1);
								run_q   <= '0;
								prev_q  <= '0;
							end
							OP_ENCODE: begin
								state_q <= ST_ENC;
							end
							OP_FLUSH: begin
								state_q <= ST_FLUSH;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_BUILD: begin
					if (scan_q == SYM_W'(SYMBOLS - 1)) begin
						scan_q <= '0;
						blen_q <= blen_q + LEN_W'(1);
						if (blen_q == LEN_W'(MAX_CODE_LEN)) begin
							state_q <= ST_BDONE;
						end
					end else begin
						scan_q <= scan_q + SYM_W'(1);
					end
				end
				ST_BDONE, ST_ERR: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ENC: begin
					if (!in_range_s1 || (lrd == '0)) begin
						state_q <= ST_ERR;
					end else begin
						buf_q  <= buf_q | ins;
						cnt_q  <= total[2:0];
						full_q <= total[5:3];
						if (total[5:3] == 3'd0) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						buf_q  <= buf_q >> 8;
						full_q <= full_q - 3'd1;
						if (full_q == 3'd1) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						buf_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/che_len_mem.sv
// Code length table: synchronous memory with per-entry valid flags for reset.
module che_len_mem
	import che_pkg::*;
#(
	parameter int SYMBOLS = SYMBOLS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  we,
	input  logic [((SYMBOLS > 1) ? $clog2(SYMBOLS) : 1)-1:0] waddr,
	input  logic [LEN_W-1:0]                      wdata,
	input  logic [((SYMBOLS > 1) ? $clog2(SYMBOLS) : 1)-1:0] raddr,
	output logic [LEN_W-1:0]                      rdata
);

	logic [LEN_W-1:0] mem [SYMBOLS];
	logic [SYMBOLS-1:0] vld_q;
	logic [LEN_W-1:0] rd_q;
	logic rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	assign rdata = rvld_q ? rd_q : '0;

endmodule

FILE: rtl/che_code_mem.sv
// Canonical code table: synchronous memory, one write and one read port.
module che_code_mem
	import che_pkg::*;
#(
	parameter int SYMBOLS      = SYMBOLS_DEF,
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((SYMBOLS > 1) ? $clog2(SYMBOLS) : 1)-1:0] waddr,
	input  logic [MAX_CODE_LEN-1:0]               wdata,
	input  logic [((SYMBOLS > 1) ? $clog2(SYMBOLS) : 1)-1:0] raddr,
	output logic [MAX_CODE_LEN-1:0]               rdata
);

	logic [MAX_CODE_LEN-1:0] mem [SYMBOLS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/che_out_reg.sv
// Output register that holds one result word until the receiver takes it.
module che_out_reg
	import che_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  che_out_t push_word,
	output logic     free,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output che_out_t rsp
);

	logic valid_q;
	che_out_t word_q;

	assign free      = !valid_q || !rsp_stall;
	assign rsp_valid = valid_q;
	assign rsp       = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= push || (valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			word_q <= push_word;
		end
	end

endmodule
